// ===== hw/rtl/swm_pkg.sv =====
// shared types and constants for the sliding window maximum unit
package swm_pkg;

  // window size register and candidate age counters
  localparam int CFG_W = 7;
  localparam int AGE_W = 7;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd3;

  // per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic             accept;  // a sample transaction is taken this cycle
    logic             purge;   // shift the row down by one, no new sample
    logic             clear;   // empty the row after this sample
    logic             drop;    // head candidate expires with this sample
    logic [CFG_W-1:0] k;       // effective window size
  } swm_ctl_t;

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    age_inc = (a == '1) ? a : a + AGE_W'(1);
  endfunction

endpackage

// ===== hw/rtl/swm_cell.sv =====
// one candidate slot of the monotonic row, fed by its older and newer neighbors
module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  swm_ctl_t                ctl,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic                    up_valid,
  input  logic [SAMPLE_WIDTH-1:0] up_value,
  input  logic [AGE_W-1:0]        up_age,
  input  logic                    prev_keep,
  output logic                    valid,
  output logic [SAMPLE_WIDTH-1:0] value,
  output logic [AGE_W-1:0]        age,
  output logic                    keep,
  output logic                    expired,
  output logic [SAMPLE_WIDTH-1:0] next_value
);

  logic                    valid_next;
  logic [SAMPLE_WIDTH-1:0] value_next;
  logic [AGE_W-1:0]        age_next;
  logic                    src_valid;
  logic [SAMPLE_WIDTH-1:0] src_value;
  logic [AGE_W-1:0]        src_age;

  // with the head dropping, every slot takes over its upper neighbor
  assign src_valid = ctl.drop ? up_valid : valid;
  assign src_value = ctl.drop ? up_value : value;
  assign src_age   = ctl.drop ? age_inc(up_age) : age_inc(age);

  assign keep    = src_valid && ($signed(src_value) > $signed(sample));
  assign expired = valid && (age_inc(age) >= ctl.k);

  always_comb begin
    valid_next = valid;
    value_next = value;
    age_next   = age;
    if (ctl.purge) begin
      valid_next = up_valid;
      value_next = up_value;
      age_next   = up_age;
    end else if (ctl.accept) begin
      if (keep) begin
        valid_next = 1'b1;
        value_next = src_value;
        age_next   = src_age;
      end else if (prev_keep) begin
        // first slot past the surviving candidates takes the new sample
        valid_next = 1'b1;
        value_next = sample;
        age_next   = '0;
      end else begin
        valid_next = 1'b0;
      end
      if (ctl.clear) begin
        valid_next = 1'b0;
      end
    end
  end

  assign next_value = value_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    age   <= age_next;
  end

endmodule

// ===== hw/rtl/sliding_window_maximum_unit.sv =====
// Sliding window maximum over a stream of signed samples, built as a row of candidate cells.
// The row holds a monotonic queue, oldest candidate in cell 0, values strictly decreasing
// toward newer cells. For each sample, normally every cell compares its candidate
// with the sample in parallel, the head may expire, and each cell loads from itself, its
// upper neighbor or the sample. Right after window_size has been lowered, the row sheds the
// candidates beyond the head that have fallen out of the window, one shift per cycle, and
// holds s_axis_tready low for those cycles. A result is given only once window_size samples
// of the current stream have arrived; a sample with tlast set empties the row after its own
// result. window_size 0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX. The result
// register lets the next sample enter while a result is being taken; while a result waits
// untaken, s_axis_tready stays low.
module sliding_window_maximum_unit
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [CFG_W-1:0]                         cfg_wdata,     // window_size
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        s_axis_tdata,  // sample
  input  logic                                     s_axis_tlast,  // end_of_stream
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        m_axis_tdata   // window_max
);

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  logic [CFG_W-1:0]        window_size;
  logic [CFG_W-1:0]        k;
  logic [AGE_W-1:0]        samples_seen;
  logic [AGE_W-1:0]        samples_seen_next;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    in_acc;
  logic                    purge_need;
  logic                    produce;
  logic [SAMPLE_WIDTH-1:0] out_data;
  swm_ctl_t                ctl;

  logic                    cell_valid   [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] cell_value   [WINDOW_MAX];
  logic [AGE_W-1:0]        cell_age     [WINDOW_MAX];
  logic                    cell_keep    [WINDOW_MAX];
  logic                    cell_expired [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] cell_next    [WINDOW_MAX];

  assign sample = s_axis_tdata[SAMPLE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  always_comb begin
    if (window_size == '0) begin
      k = CFG_W'(1);
    end else if (32'(window_size) > WINDOW_MAX) begin
      k = CFG_W'(WINDOW_MAX);
    end else begin
      k = window_size;
    end
  end

  // a second expired candidate has to leave before the next sample can enter
  assign purge_need    = cell_expired[1];
  assign s_axis_tready = !purge_need && (!m_axis_tvalid || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ctl.accept = in_acc;
    ctl.purge  = purge_need;
    ctl.clear  = in_acc && s_axis_tlast;
    ctl.drop   = cell_expired[0];
    ctl.k      = k;
  end

  genvar i;
  generate
    for (i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic                    up_valid;
      logic [SAMPLE_WIDTH-1:0] up_value;
      logic [AGE_W-1:0]        up_age;
      logic                    prev_keep;

      if (i == WINDOW_MAX - 1) begin : g_top
        assign up_valid = 1'b0;
        assign up_value = '0;
        assign up_age   = '0;
      end else begin : g_mid
        assign up_valid = cell_valid[i+1];
        assign up_value = cell_value[i+1];
        assign up_age   = cell_age[i+1];
      end

      if (i == 0) begin : g_head
        assign prev_keep = 1'b1;
      end else begin : g_body
        assign prev_keep = cell_keep[i-1];
      end

      swm_cell #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .sample     (sample),
        .up_valid   (up_valid),
        .up_value   (up_value),
        .up_age     (up_age),
        .prev_keep  (prev_keep),
        .valid      (cell_valid[i]),
        .value      (cell_value[i]),
        .age        (cell_age[i]),
        .keep       (cell_keep[i]),
        .expired    (cell_expired[i]),
        .next_value (cell_next[i])
      );
    end
  endgenerate

  assign samples_seen_next = age_inc(samples_seen);
  assign produce           = samples_seen_next >= k;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
    end else if (in_acc) begin
      samples_seen <= s_axis_tlast ? '0 : samples_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_axis_tvalid <= produce;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // the head after this step is the window maximum
  always_ff @(posedge clk) begin
    if (in_acc && produce) begin
      out_data <= cell_next[0];
    end
  end

  assign m_axis_tdata = TDATA_W'(out_data);

`ifndef SYNTHESIS
  a_no_accept_during_purge: assert property (@(posedge clk) disable iff (rst)
    !(purge_need && in_acc))
    else $error("sample transaction taken while the row was shedding expired candidates");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tlast) |=> !cell_valid[0])
    else $error("row not emptied after end of stream");

  a_head_after_sample: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !s_axis_tlast) |=> cell_valid[0])
    else $error("row empty right after taking a sample");
`endif

endmodule
